// File: rtl/fwrle_pkg.sv
// ----------------------------------------------------------------------------
// fwrle_pkg: shared types and constants of the fixed width rle encoder
// Item structs, register indexes, run limit and value width helpers.
// ----------------------------------------------------------------------------
package fwrle_pkg;

	// longest run one record can hold
	localparam logic [15:0] MAX_RUN = 16'hFFFF;

	// configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_BYTES  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_OUT_CAPACITY = 1'b1;
	localparam int CFG_DATA_W = 32;

	// reset values of the registers
	localparam logic [3:0]  VALUE_BYTES_RST  = 4'd1;
	localparam logic [31:0] OUT_CAPACITY_RST = 32'hFFFF_FFFF;

	// bytes of a record besides the value itself
	localparam logic [3:0] COUNT_BYTES = 4'd2;

	// output queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// record status codes
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_OVERFLOW = 1'b1;

	typedef struct packed {
		logic [63:0] value;
		logic        last_value;
	} in_item_t;

	typedef struct packed {
		logic [63:0] run_value;
		logic [15:0] run_length;
		logic        status;
		logic        last_record;
	} out_item_t;

	// up to two records pushed per accepted item, rec0 first
	typedef struct packed {
		logic      push0;
		logic      push1;
		out_item_t rec0;
		out_item_t rec1;
	} push_t;

	// value width clamped into 1..8 bytes
	function automatic logic [3:0] eff_bytes(input logic [3:0] vb);
		logic [3:0] b;
		b = vb;
		if (vb == 4'd0) begin
			b = 4'd1;
		end else if (vb > 4'd8) begin
			b = 4'd8;
		end
		return b;
	endfunction

	// byte lane mask for the effective width
	function automatic logic [63:0] value_mask(input logic [3:0] vb);
		logic [63:0] m;
		logic [3:0]  b;
		b = eff_bytes(vb);
		for (int i = 0; i < 8; i++) begin
			m[8*i +: 8] = {8{4'(i) < b}};
		end
		return m;
	endfunction

endpackage

// File: rtl/fwrle_core.sv
// ----------------------------------------------------------------------------
// fwrle_core: run tracking and record generation
// Holds the registers and the run state, and forms up to two records per item.
// ----------------------------------------------------------------------------
module fwrle_core import fwrle_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
	input  logic                   accept,
	input  in_item_t               item,
	output push_t                  push
);

	logic [3:0]  value_bytes_q;
	logic [31:0] out_capacity_q;

	logic [63:0] prev_value_q;
	logic [15:0] run_count_q;
	logic        have_prev_q;
	logic [32:0] bytes_written_q;
	logic        failed_q;

	logic [63:0] mask;
	logic [63:0] v;
	logic [3:0]  rec_bytes;
	logic [33:0] sum1;
	logic [33:0] sum2;
	logic [33:0] cap;
	logic        last;
	logic        extend;
	logic        brk;
	logic        fail1;
	logic        fail_fin;
	logic [63:0] fin_value;
	logic [15:0] fin_count;
	out_item_t   brk_rec;
	out_item_t   fin_rec;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_bytes_q  <= VALUE_BYTES_RST;
			out_capacity_q <= OUT_CAPACITY_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_VALUE_BYTES:  value_bytes_q  <= cfg_wr_data[3:0];
				CFG_OUT_CAPACITY: out_capacity_q <= cfg_wr_data[31:0];
				default:          ;
			endcase
		end
	end

	// run compare and budget checks
	always_comb begin
		mask      = value_mask(value_bytes_q);
		v         = item.value & mask;
		last      = item.last_value;
		rec_bytes = eff_bytes(value_bytes_q) + COUNT_BYTES;
		cap       = {2'b00, out_capacity_q};
		sum1      = {1'b0, bytes_written_q} + 34'(rec_bytes);
		sum2      = {1'b0, bytes_written_q} + 34'({rec_bytes, 1'b0});
		extend    = have_prev_q && ((prev_value_q & mask) == v) && (run_count_q < MAX_RUN);
		brk       = have_prev_q && !extend;
		fail1     = sum1 > cap;
		// final record budget: after a successful break it follows that record
		fail_fin  = brk ? (sum2 > cap) : fail1;
		if (brk) begin
			fin_value = v;
			fin_count = 16'd1;
		end else if (have_prev_q) begin
			fin_value = prev_value_q & mask;
			fin_count = run_count_q + 16'd1;
		end else begin
			fin_value = v;
			fin_count = 16'd1;
		end
	end

	// records
	always_comb begin
		brk_rec.run_value   = fail1 ? 64'd0 : (prev_value_q & mask);
		brk_rec.run_length  = fail1 ? 16'd0 : run_count_q;
		brk_rec.status      = fail1 ? STATUS_OVERFLOW : STATUS_OK;
		// only a failing break closes the buffer itself
		brk_rec.last_record = last && fail1;

		fin_rec.run_value   = fail_fin ? 64'd0 : fin_value;
		fin_rec.run_length  = fail_fin ? 16'd0 : fin_count;
		fin_rec.status      = fail_fin ? STATUS_OVERFLOW : STATUS_OK;
		fin_rec.last_record = 1'b1;

		push.push0 = accept && !failed_q && (brk || last);
		push.push1 = accept && !failed_q && brk && !fail1 && last;
		push.rec0  = brk ? brk_rec : fin_rec;
		push.rec1  = fin_rec;
	end

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_value_q    <= '0;
			run_count_q     <= '0;
			have_prev_q     <= 1'b0;
			bytes_written_q <= '0;
			failed_q        <= 1'b0;
		end else if (accept) begin
			if (last) begin
				prev_value_q    <= '0;
				run_count_q     <= '0;
				have_prev_q     <= 1'b0;
				bytes_written_q <= '0;
				failed_q        <= 1'b0;
			end else if (!failed_q) begin
				if (!have_prev_q) begin
					prev_value_q <= v;
					run_count_q  <= 16'd1;
					have_prev_q  <= 1'b1;
				end else if (extend) begin
					run_count_q <= run_count_q + 16'd1;
				end else if (fail1) begin
					failed_q <= 1'b1;
				end else begin
					prev_value_q    <= v;
					run_count_q     <= 16'd1;
					bytes_written_q <= sum1[32:0];
				end
			end
		end
	end

endmodule

// File: rtl/fwrle_queue.sv
// ----------------------------------------------------------------------------
// fwrle_queue: output record queue
// Takes up to two records a cycle, hands out one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module fwrle_queue import fwrle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     push,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	out_item_t        entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;
	logic [QCNT_W-1:0] n_push;

	// handshake side
	always_comb begin
		out_valid = count_q != '0;
		out_item  = entry_q[rd_ptr_q];
		pop       = out_valid && out_ready;
		n_push    = QCNT_W'(push.push0) + QCNT_W'(push.push1);
		room      = count_q <= QCNT_W'(QUEUE_DEPTH - 2);
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push.push0) begin
			entry_q[wr_ptr_q] <= push.rec0;
		end
		if (push.push1) begin
			entry_q[wr_ptr_q + QPTR_W'(1)] <= push.rec1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + n_push - QCNT_W'(pop);
		end
	end

endmodule

// File: rtl/fixed_width_rle_encoder.sv
// ----------------------------------------------------------------------------
// fixed_width_rle_encoder: run length encoder with a 16 bit repeat count
// Merges equal neighboring values into (value, count) records under a budget.
// ----------------------------------------------------------------------------
// One input item is taken every clock cycle; its run compare, count update and
// budget check finish in that cycle and its records land in a four entry output
// queue, one record leaving per cycle while out_ready is high. An item that
// breaks a run and also ends a buffer gives two records, so sustained rate is
// bounded by the output side at one record per cycle; in_ready falls while
// the queue has fewer than two free entries. Configuration writes take effect
// at once and are meant to happen only while the encoder is idle.
module fixed_width_rle_encoder import fwrle_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_item_t               in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_item_t              out_item
);

	push_t push;
	logic  accept;

	// input handshake
	assign accept = in_valid && in_ready;

	fwrle_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.accept      (accept),
		.item        (in_item),
		.push        (push)
	);

	fwrle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// File: tb/tb_fixed_width_rle_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_width_rle_encoder: self-checking bench of the run length encoder
// A directed table walks the width clamps, run breaks, two-record items,
// overflow handling and mid-buffer register changes.
// Random buffers follow under random idling and one long output stall.
// Every record is checked field by field against a bench-side encoder model or the typed rows of the table.
// ----------------------------------------------------------------------------
module tb_fixed_width_rle_encoder;
	import fwrle_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 4;
	localparam int SETTLE_CYCLES  = 6;
	localparam int TAIL_CYCLES    = 16;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 10;
	localparam int RANDOM_ITEMS   = 340;
	localparam int NUM_DIRECTED   = 35;

	// directed table rows
	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_CHECKED,
		ROW_TYPED
	} row_kind_e;

	typedef struct packed {
		row_kind_e   kind;
		logic [63:0] data;
		logic        flag;
		logic [1:0]  n_typed;
		out_item_t   typed0;
		out_item_t   typed1;
	} stim_row_t;

	localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		// after reset: one byte values, upper bytes ignored
		'{ROW_TYPED, 64'hFFFF_FFFF_FFFF_FFAB, 1'b1, 2'd1,
			'{64'h0000_0000_0000_00AB, 16'd1, STATUS_OK, 1'b1}, '0},
		'{ROW_TYPED, 64'h0, 1'b0, 2'd0, '0, '0},
		'{ROW_TYPED, 64'h0, 1'b0, 2'd0, '0, '0},
		'{ROW_TYPED, 64'h0000_0000_0000_0100, 1'b0, 2'd0, '0, '0},
		// break on the last value gives two records
		'{ROW_TYPED, 64'h1, 1'b1, 2'd2,
			'{64'h0, 16'd3, STATUS_OK, 1'b0},
			'{64'h1, 16'd1, STATUS_OK, 1'b1}},
		// width zero acts as one byte
		'{ROW_CFG, 64'd0, CFG_VALUE_BYTES, 2'd0, '0, '0},
		'{ROW_CHECKED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 2'd0, '0, '0},
		'{ROW_CHECKED, 64'h0000_0000_0000_00FF, 1'b1, 2'd0, '0, '0},
		// width above eight acts as eight bytes
		'{ROW_CFG, 64'd15, CFG_VALUE_BYTES, 2'd0, '0, '0},
		'{ROW_CHECKED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 2'd0, '0, '0},
		'{ROW_CHECKED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 2'd0, '0, '0},
		'{ROW_CHECKED, 64'h0, 1'b0, 2'd0, '0, '0},
		'{ROW_CHECKED, 64'h0, 1'b1, 2'd0, '0, '0},
		// zero budget: overflow on the last value, then overflow mid-buffer
		'{ROW_CFG, 64'd8, CFG_VALUE_BYTES, 2'd0, '0, '0},
		'{ROW_CFG, 64'd0, CFG_OUT_CAPACITY, 2'd0, '0, '0},
		'{ROW_TYPED, 64'h5, 1'b1, 2'd1,
			'{64'h0, 16'd0, STATUS_OVERFLOW, 1'b1}, '0},
		'{ROW_TYPED, 64'h7, 1'b0, 2'd0, '0, '0},
		'{ROW_TYPED, 64'h8, 1'b0, 2'd1,
			'{64'h0, 16'd0, STATUS_OVERFLOW, 1'b0}, '0},
		'{ROW_TYPED, 64'h9, 1'b0, 2'd0, '0, '0},
		'{ROW_TYPED, 64'h9, 1'b1, 2'd0, '0, '0},
		// budget of exactly two eight byte records
		'{ROW_CFG, 64'd20, CFG_OUT_CAPACITY, 2'd0, '0, '0},
		'{ROW_CHECKED, 64'hA5A5_0000_FFFF_0001, 1'b0, 2'd0, '0, '0},
		'{ROW_CHECKED, 64'h5A5A_FFFF_0000_0002, 1'b0, 2'd0, '0, '0},
		'{ROW_CHECKED, 64'h8000_0000_0000_0003, 1'b0, 2'd0, '0, '0},
		'{ROW_TYPED, 64'h0000_0000_0000_0004, 1'b1, 2'd1,
			'{64'h0, 16'd0, STATUS_OVERFLOW, 1'b1}, '0},
		// two byte values, full budget
		'{ROW_CFG, 64'd2, CFG_VALUE_BYTES, 2'd0, '0, '0},
		'{ROW_CFG, 64'hFFFF_FFFF, CFG_OUT_CAPACITY, 2'd0, '0, '0},
		'{ROW_CHECKED, 64'h5A5A_0F0F_C3C3_1234, 1'b0, 2'd0, '0, '0},
		'{ROW_CHECKED, 64'hDEAD_0000_0000_1234, 1'b0, 2'd0, '0, '0},
		'{ROW_CHECKED, 64'h0000_0000_0000_5678, 1'b1, 2'd0, '0, '0},
		'{ROW_CHECKED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 2'd0, '0, '0},
		// width change inside a buffer
		'{ROW_CFG, 64'd8, CFG_VALUE_BYTES, 2'd0, '0, '0},
		'{ROW_CHECKED, 64'h1122_3344_5566_7788, 1'b0, 2'd0, '0, '0},
		'{ROW_CFG, 64'd1, CFG_VALUE_BYTES, 2'd0, '0, '0},
		'{ROW_CHECKED, 64'h0000_0000_0000_0088, 1'b1, 2'd0, '0, '0}
	};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wr_data;
	logic                   in_valid;
	logic                   in_ready;
	in_item_t               in_item;
	logic                   out_valid;
	logic                   out_ready;
	out_item_t              out_item;

	// bench-side encoder state and register copies
	logic [63:0] run_prev;
	logic [15:0] run_cnt;
	logic        run_open;
	logic [32:0] bytes_used;
	logic        overflowed;
	logic [3:0]  cfg_value_bytes;
	logic [31:0] cfg_capacity;

	out_item_t expected_records [$];
	int        mismatches    = 0;
	int        quiet_cycles  = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        holds_asked   = 0;
	int        holds_done    = 0;

	fixed_width_rle_encoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item)
	);

	// clock
	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// value width clamped into 1..8 bytes
	function automatic int lane_bytes(input logic [3:0] vb);
		if (vb == 4'd0) begin
			return 1;
		end else if (vb > 4'd8) begin
			return 8;
		end
		return int'(vb);
	endfunction

	function automatic logic [63:0] lane_mask(input logic [3:0] vb);
		int nbytes;
		nbytes = lane_bytes(vb);
		if (nbytes == 8) begin
			return {64{1'b1}};
		end
		return (64'd1 << (8 * nbytes)) - 64'd1;
	endfunction

	task automatic clear_run();
		run_prev   = '0;
		run_cnt    = '0;
		run_open   = 1'b0;
		bytes_used = '0;
		overflowed = 1'b0;
	endtask

	// close the open run into a record, or into an overflow status
	task automatic emit_record(input logic lst, output logic ok, output out_item_t rec);
		logic [33:0] need;
		need = {1'b0, bytes_used} + 34'(lane_bytes(cfg_value_bytes) + 2);
		if (need > {2'b00, cfg_capacity}) begin
			rec        = '{64'd0, 16'd0, STATUS_OVERFLOW, lst};
			overflowed = 1'b1;
			ok         = 1'b0;
		end else begin
			rec        = '{run_prev & lane_mask(cfg_value_bytes), run_cnt, STATUS_OK, lst};
			bytes_used = need[32:0];
			ok         = 1'b1;
		end
	endtask

	// records caused by one accepted item
	task automatic encode_item(input in_item_t it, output int n,
			output out_item_t r0, output out_item_t r1);
		logic [63:0] mask;
		logic [63:0] v;
		logic        ok;
		mask = lane_mask(cfg_value_bytes);
		v    = it.value & mask;
		n    = 0;
		r0   = '0;
		r1   = '0;
		ok   = 1'b1;
		// after an overflow the rest of the buffer is dropped
		if (overflowed) begin
			if (it.last_value) begin
				clear_run();
			end
			return;
		end
		if (!run_open) begin
			run_prev = v;
			run_cnt  = 16'd1;
			run_open = 1'b1;
		end else if ((run_prev & mask) == v && run_cnt < MAX_RUN) begin
			run_cnt++;
		end else begin
			emit_record(it.last_value, ok, r0);
			n = 1;
			if (ok) begin
				run_prev = v;
				run_cnt  = 16'd1;
			end
		end
		if (!ok) begin
			if (it.last_value) begin
				clear_run();
			end
		end else if (it.last_value) begin
			if (n == 0) begin
				emit_record(1'b1, ok, r0);
			end else begin
				emit_record(1'b1, ok, r1);
				r0.last_record = 1'b0;
			end
			n++;
			clear_run();
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= data;
		@(posedge clk);
		if (idx == CFG_VALUE_BYTES) begin
			cfg_value_bytes = data[3:0];
		end else begin
			cfg_capacity = data;
		end
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering items and wait until the encoder has gone quiet
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (expected_records.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// offer one item after a random gap, then queue its records
	task automatic send_item(input in_item_t it, input logic typed, input logic [1:0] n_typed,
			input out_item_t t0, input out_item_t t1);
		int        gap;
		int        n;
		out_item_t r0;
		out_item_t r1;
		gap = 0;
		while ($urandom_range(99, 0) < send_idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do begin
			@(posedge clk);
		end while (!in_ready);
		encode_item(it, n, r0, r1);
		if (typed) begin
			n  = int'(n_typed);
			r0 = t0;
			r1 = t1;
		end
		if (n >= 1) begin
			expected_records.push_back(r0);
		end
		if (n == 2) begin
			expected_records.push_back(r1);
		end
	endtask

	// random buffers made of short runs, with some noise and early ends
	task automatic run_random(input int item_total);
		int          counted;
		int          seg_left;
		int          buf_left;
		int          run_left;
		logic        noisy;
		logic [63:0] run_val;
		logic [31:0] cap;
		in_item_t    it;
		counted  = 0;
		seg_left = 0;
		buf_left = 0;
		run_left = 0;
		noisy    = 1'b0;
		run_val  = '0;
		while (counted < item_total) begin
			// new register setting between segments, often mid-buffer
			if (seg_left == 0) begin
				settle_idle();
				case ($urandom_range(9, 0))
					0: cap = '0;
					1, 2: cap = $urandom_range(120, 0);
					3, 4: cap = $urandom;
					default: cap = OUT_CAPACITY_RST;
				endcase
				write_reg(CFG_VALUE_BYTES, $urandom_range(15, 0));
				write_reg(CFG_OUT_CAPACITY, cap);
				seg_left = $urandom_range(90, 30);
			end
			if (buf_left == 0) begin
				buf_left = $urandom_range(16, 1);
				noisy    = ($urandom_range(9, 0) == 0);
			end
			if (run_left == 0) begin
				run_left = ($urandom_range(7, 0) == 0) ? $urandom_range(12, 5)
					: $urandom_range(3, 1);
				run_val  = {$urandom, $urandom};
			end
			if (noisy) begin
				it.value      = {$urandom, $urandom};
				it.last_value = (buf_left == 1) || ($urandom_range(7, 0) == 0);
			end else begin
				// bytes outside the width change freely within a run
				it.value      = run_val ^ ({$urandom, $urandom} & ~lane_mask(cfg_value_bytes));
				it.last_value = (buf_left == 1);
			end
			send_item(it, 1'b0, 2'd0, '0, '0);
			buf_left = it.last_value ? 0 : buf_left - 1;
			run_left--;
			seg_left--;
			counted++;
		end
	endtask

	// receiver ready, with random stalls and requested long hold-offs
	initial begin : sink_ready
		int hold_count;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				out_ready <= 1'b0;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
					@(posedge clk);
				end
				holds_done++;
			end else begin
				out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	// compare each record with the oldest expected one
	always @(posedge clk) begin : record_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_records.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("unexpected record: value=%h len=%0d st=%0b last=%0b",
						out_item.run_value, out_item.run_length, out_item.status,
						out_item.last_record);
				end
			end else begin
				want = expected_records.pop_front();
				if (out_item.run_value !== want.run_value
						|| out_item.run_length !== want.run_length
						|| out_item.status !== want.status
						|| out_item.last_record !== want.last_record) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("record mismatch: expected value=%h len=%0d st=%0b last=%0b",
							want.run_value, want.run_length, want.status, want.last_record);
						$display("                 actual   value=%h len=%0d st=%0b last=%0b",
							out_item.run_value, out_item.run_length, out_item.status,
							out_item.last_record);
					end
				end
			end
		end
	end

	// watchdog on cycles without any accepted item or taken record
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// main sequence
	initial begin : stimulus
		stim_row_t   row;
		in_item_t    it;
		int          i;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_index   = '0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		in_item     = '0;
		cfg_value_bytes = VALUE_BYTES_RST;
		cfg_capacity    = OUT_CAPACITY_RST;
		clear_run();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		send_idle_pct = 38;
		recv_idle_pct = 45;
		for (i = 0; i < NUM_DIRECTED; i++) begin
			row = DIRECTED_ROWS[i];
			if (row.kind == ROW_CFG) begin
				settle_idle();
				write_reg(row.flag, row.data[CFG_DATA_W-1:0]);
			end else begin
				it.value      = row.data;
				it.last_value = row.flag;
				send_item(it, row.kind == ROW_TYPED, row.n_typed, row.typed0, row.typed1);
			end
		end

		// random buffers under three idling mixes
		run_random(RANDOM_ITEMS);
		send_idle_pct = 45;
		recv_idle_pct = 38;
		run_random(RANDOM_ITEMS);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// drained first so the long hold-off meets a busy sender
		settle_idle();
		holds_asked++;
		run_random(RANDOM_ITEMS);

		// drain and verdict
		settle_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
